FILE: design/polygon_fan_triangulator_top_defines.svh
// Assertion macros for the checker file of the polygon fan triangulator.
`ifndef POLYGON_FAN_TRIANGULATOR_TOP_DEFINES_SVH
`define POLYGON_FAN_TRIANGULATOR_TOP_DEFINES_SVH

// Checks a property on every clock edge outside reset.
`define PFT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks a property on every clock edge, reset included.
`define PFT_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/pft_pkg.sv
// Package with the types and constants shared by the polygon fan triangulator modules.
package pft_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int unsigned TDATA_OUT_W = 72;

	localparam logic KIND_TRIANGLE = 1'b0;
	localparam logic KIND_ERROR    = 1'b1;

	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_SHORT_FACE = 2'd1;
	localparam logic [1:0] ERR_BAD_INDEX  = 2'd2;

	localparam logic REG_POINT_COUNT      = 1'b0;
	localparam logic REG_COUNTER_CLOCKWISE = 1'b1;

	localparam logic [31:0] END_OF_FACE = 32'hFFFF_FFFF;
	localparam logic [1:0]  FULL_FACE   = 2'd3;
	localparam logic [15:0] FACE_MAX    = 16'hFFFF;

	typedef struct packed {
		logic        kind;
		logic [15:0] apex;
		logic [15:0] prev;
		logic [15:0] cur;
		logic [15:0] face;
		logic [1:0]  code;
	} pft_item_t;

endpackage

FILE: design/pft_front.sv
// Front part: accepts vertex indices, tracks the face state and produces result items.
module pft_front #(
	parameter int unsigned MAX_POINTS = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [31:0]        in_index,
	input  logic               in_last,
	input  logic [16:0]        point_count,
	output logic               push,
	output pft_pkg::pft_item_t push_item
);

	localparam logic [31:0] MaxIdx = 32'(MAX_POINTS);

	logic [15:0] apex_q, prev_q, face_q;
	logic [1:0]  cnt_q;
	logic        drop_q;

	logic [15:0] apex_d, prev_d, face_d;
	logic [1:0]  cnt_d;
	logic        drop_d;
	logic        accept, bad, err, clear;
	logic [1:0]  err_code;
	logic [15:0] cur;

	assign accept = in_valid && in_ready;
	assign cur    = in_index[15:0];
	assign bad    = in_index[31] || (in_index >= {15'd0, point_count}) || (in_index >= MaxIdx);

	always_comb begin
		apex_d   = apex_q;
		prev_d   = prev_q;
		face_d   = face_q;
		cnt_d    = cnt_q;
		drop_d   = drop_q;
		err      = 1'b0;
		err_code = pft_pkg::ERR_NONE;
		clear    = 1'b0;
		push     = 1'b0;
		if (accept) begin
			if (drop_q) begin
				clear = in_last;
			end else if (in_index == pft_pkg::END_OF_FACE) begin
				if (cnt_q != pft_pkg::FULL_FACE) begin
					err      = 1'b1;
					err_code = pft_pkg::ERR_SHORT_FACE;
				end else begin
					cnt_d = 2'd0;
					if (face_q != pft_pkg::FACE_MAX) begin
						face_d = face_q + 16'd1;
					end
					clear = in_last;
				end
			end else if (bad) begin
				err      = 1'b1;
				err_code = pft_pkg::ERR_BAD_INDEX;
			end else if (cnt_q == 2'd0) begin
				apex_d = cur;
				cnt_d  = 2'd1;
				if (in_last) begin
					err      = 1'b1;
					err_code = pft_pkg::ERR_SHORT_FACE;
				end
			end else if (cnt_q == 2'd1) begin
				prev_d = cur;
				cnt_d  = 2'd2;
				if (in_last) begin
					err      = 1'b1;
					err_code = pft_pkg::ERR_SHORT_FACE;
				end
			end else begin
				push   = 1'b1;
				prev_d = cur;
				cnt_d  = pft_pkg::FULL_FACE;
				clear  = in_last;
			end
			if (err) begin
				push = 1'b1;
				if (in_last) begin
					clear = 1'b1;
				end else begin
					drop_d = 1'b1;
				end
			end
			if (clear) begin
				apex_d = 16'd0;
				prev_d = 16'd0;
				face_d = 16'd0;
				cnt_d  = 2'd0;
				drop_d = 1'b0;
			end
		end
	end

	always_comb begin
		push_item.kind = err ? pft_pkg::KIND_ERROR : pft_pkg::KIND_TRIANGLE;
		push_item.apex = apex_q;
		push_item.prev = prev_q;
		push_item.cur  = cur;
		push_item.face = face_q;
		push_item.code = err_code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			apex_q <= 16'd0;
			prev_q <= 16'd0;
			face_q <= 16'd0;
			cnt_q  <= 2'd0;
			drop_q <= 1'b0;
		end else begin
			apex_q <= apex_d;
			prev_q <= prev_d;
			face_q <= face_d;
			cnt_q  <= cnt_d;
			drop_q <= drop_d;
		end
	end

endmodule

FILE: design/pft_queue.sv
// Short queue of result items between the front and back parts.
module pft_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  pft_pkg::pft_item_t push_item,
	input  logic               pop,
	output logic               has_room,
	output logic               not_empty,
	output pft_pkg::pft_item_t head_item
);

	pft_pkg::pft_item_t mem_q [pft_pkg::QUEUE_DEPTH];

	logic [pft_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [pft_pkg::QUEUE_CNT_W-1:0] count_q;
	logic                            do_push, do_pop;

	assign has_room  = count_q != pft_pkg::QUEUE_CNT_W'(pft_pkg::QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign head_item = mem_q[rd_ptr_q];
	assign do_push   = push && has_room;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/pft_back.sv
// Back part: orders the triangle corners and holds the result item on the output stream.
module pft_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                counter_clockwise,
	input  logic                                head_valid,
	input  pft_pkg::pft_item_t                  head_item,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [pft_pkg::TDATA_OUT_W-1:0]     out_data,
	output logic                                out_kind
);

	logic                                valid_q;
	logic                                kind_q;
	logic [pft_pkg::TDATA_OUT_W-1:0]     data_q;
	logic [15:0]                         c1, c2, c3;
	logic                                is_err;

	assign pop     = head_valid && (!valid_q || out_ready);
	assign is_err  = head_item.kind == pft_pkg::KIND_ERROR;

	always_comb begin
		c1 = head_item.apex;
		c2 = counter_clockwise ? head_item.prev : head_item.cur;
		c3 = counter_clockwise ? head_item.cur : head_item.prev;
		if (is_err) begin
			c1 = 16'd0;
			c2 = 16'd0;
			c3 = 16'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= head_item.kind;
			data_q <= {6'd0, head_item.code, head_item.face, c3, c2, c1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_kind  = kind_q;

endmodule

FILE: design/polygon_fan_triangulator_top.sv
// Top level of the polygon fan triangulator.
// The block takes one vertex index per cycle and returns at most one result item per index:
// a fan triangle or an error report. The front part registers the new face state on the
// edge that accepts an index, so an index is accepted in every cycle while the four-entry
// result queue has room. With an empty queue and a free output, a result is written into
// the queue and then into the output register before it is presented on the output.
// Configuration writes are always taken and must arrive only while the block is idle.
module polygon_fan_triangulator_top #(
	parameter int unsigned MAX_POINTS = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [16:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // vertex_index
	input  logic        s_tlast,   // last_in_list
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // corner_first, corner_second, corner_third, face_number, error_code
	output logic        m_tuser    // result_kind
);

	logic [16:0]        point_count_q;
	logic               ccw_q;
	logic               push, pop, has_room, not_empty;
	pft_pkg::pft_item_t push_item, head_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= 17'd0;
			ccw_q         <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				pft_pkg::REG_POINT_COUNT:       point_count_q <= cfg_data;
				pft_pkg::REG_COUNTER_CLOCKWISE: ccw_q         <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign s_tready = has_room;

	pft_front #(
		.MAX_POINTS(MAX_POINTS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_index   (s_tdata),
		.in_last    (s_tlast),
		.point_count(point_count_q),
		.push       (push),
		.push_item  (push_item)
	);

	pft_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.has_room (has_room),
		.not_empty(not_empty),
		.head_item(head_item)
	);

	pft_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.counter_clockwise(ccw_q),
		.head_valid       (not_empty),
		.head_item        (head_item),
		.pop              (pop),
		.out_valid        (m_tvalid),
		.out_ready        (m_tready),
		.out_data         (m_tdata),
		.out_kind         (m_tuser)
	);

endmodule

FILE: design/pft_checker.sv
// Checker on the output stream of the polygon fan triangulator, bound to the top level.
`include "polygon_fan_triangulator_top_defines.svh"

module pft_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic        m_tuser
);

	`PFT_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "Stalled result item changed.")
	`PFT_ASSERT(a_tri_no_code, m_tvalid && m_tuser == pft_pkg::KIND_TRIANGLE |-> m_tdata[65:64] == pft_pkg::ERR_NONE && m_tdata[71:66] == 6'd0, "Triangle item carries an error code.")
	`PFT_ASSERT(a_err_fields, m_tvalid && m_tuser == pft_pkg::KIND_ERROR |-> m_tdata[47:0] == 48'd0 && (m_tdata[65:64] == pft_pkg::ERR_SHORT_FACE || m_tdata[65:64] == pft_pkg::ERR_BAD_INDEX), "Error item has bad fields.")
	`PFT_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !m_tvalid, "Result item shown during reset.")

endmodule

bind polygon_fan_triangulator_top pft_checker u_pft_checker (.*);

FILE: test/polygon_fan_triangulator_top_tb.sv
// Self-checking testbench for the polygon fan triangulator: fan triangles and error reports.
`timescale 1ns / 1ps

module polygon_fan_triangulator_top_tb;

	localparam int unsigned MAX_POINTS = 65536;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned ITEMS_PER_PHASE = 100;

	typedef struct packed {
		logic [31:0] vidx;
		logic        last;
	} vertex_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = pft_pkg::REG_POINT_COUNT;
	logic [16:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic        m_tuser;

	vertex_item_t       index_feed[$];
	pft_pkg::pft_item_t fan_expected[$];

	// Predicted block state and configuration.
	logic [16:0] point_limit = 17'd0;
	logic        ccw = 1'b1;
	logic [15:0] fan_apex = '0;
	logic [15:0] fan_prev = '0;
	logic [1:0]  face_fill = '0;
	logic [15:0] faces_done = '0;
	logic        dropping = 1'b0;

	int unsigned cycles = 0;
	int unsigned mismatches = 0;
	int unsigned items_queued = 0;
	logic        in_taken = 1'b0;
	int          burst_left = 0;
	int          gap_left = 0;
	logic [15:0] ready_pattern = '1;
	logic [3:0]  ready_pos = '0;
	int          ready_age = 0;

	polygon_fan_triangulator_top #(
		.MAX_POINTS(MAX_POINTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic clear_list();
		fan_apex = '0;
		fan_prev = '0;
		face_fill = '0;
		faces_done = '0;
		dropping = 1'b0;
	endtask

	task automatic report_error(input logic [1:0] code, input logic last);
		pft_pkg::pft_item_t res;
		res = '0;
		res.kind = pft_pkg::KIND_ERROR;
		res.face = faces_done;
		res.code = code;
		fan_expected.push_back(res);
		if (last) begin
			clear_list();
		end else begin
			dropping = 1'b1;
		end
	endtask

	task automatic fan_step(input logic [31:0] raw, input logic last);
		pft_pkg::pft_item_t res;
		logic [31:0]        limit;
		logic [15:0]        cur;
		limit = (point_limit > MAX_POINTS) ? MAX_POINTS : point_limit;
		if (dropping) begin
			if (last) begin
				clear_list();
			end
			return;
		end
		if (raw == pft_pkg::END_OF_FACE) begin
			if (face_fill < pft_pkg::FULL_FACE) begin
				report_error(pft_pkg::ERR_SHORT_FACE, last);
			end else begin
				face_fill = '0;
				if (faces_done != pft_pkg::FACE_MAX) begin
					faces_done++;
				end
				if (last) begin
					clear_list();
				end
			end
			return;
		end
		if (raw[31] || raw >= limit) begin
			report_error(pft_pkg::ERR_BAD_INDEX, last);
			return;
		end
		cur = raw[15:0];
		if (face_fill == 2'd0) begin
			fan_apex = cur;
			face_fill = 2'd1;
			if (last) begin
				report_error(pft_pkg::ERR_SHORT_FACE, 1'b1);
			end
			return;
		end
		if (face_fill == 2'd1) begin
			fan_prev = cur;
			face_fill = 2'd2;
			if (last) begin
				report_error(pft_pkg::ERR_SHORT_FACE, 1'b1);
			end
			return;
		end
		res.kind = pft_pkg::KIND_TRIANGLE;
		res.apex = fan_apex;
		res.prev = ccw ? fan_prev : cur;
		res.cur = ccw ? cur : fan_prev;
		res.face = faces_done;
		res.code = pft_pkg::ERR_NONE;
		fan_expected.push_back(res);
		fan_prev = cur;
		face_fill = pft_pkg::FULL_FACE;
		if (last) begin
			clear_list();
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Monitor: takes input items into the predictor and checks result items.
	always @(posedge clk) begin
		pft_pkg::pft_item_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
		if (arst_n && s_tvalid && s_tready) begin
			fan_step(s_tdata, s_tlast);
			in_taken = 1'b1;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (fan_expected.size() == 0) begin
				$error("result item with none expected: kind %0d, data %h", m_tuser, m_tdata);
				mismatches++;
			end else begin
				want = fan_expected.pop_front();
				check_field("result_kind", 16'(want.kind), 16'(m_tuser));
				check_field("corner_first", want.apex, m_tdata[15:0]);
				check_field("corner_second", want.prev, m_tdata[31:16]);
				check_field("corner_third", want.cur, m_tdata[47:32]);
				check_field("face_number", want.face, m_tdata[63:48]);
				check_field("error_code", 16'(want.code), 16'(m_tdata[65:64]));
			end
		end
	end

	// Driver: sends items in bursts with random gaps between them.
	always @(negedge clk) begin
		vertex_item_t item;
		if (arst_n && (!s_tvalid || in_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (index_feed.size() > 0) begin
				item = index_feed.pop_front();
				s_tdata <= item.vidx;
				s_tlast <= item.last;
				s_tvalid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		in_taken = 1'b0;
	end

	// Receiver stalls follow a pattern that changes now and then.
	always @(negedge clk) begin
		if (ready_age == 0) begin
			case ($urandom_range(0, 2))
				0: ready_pattern = '1;
				1: ready_pattern = 16'($urandom);
				default: ready_pattern = 16'($urandom & $urandom);
			endcase
			ready_age = $urandom_range(16, 96);
		end
		ready_age--;
		m_tready <= ready_pattern[ready_pos];
		ready_pos++;
	end

	task automatic push_index(input logic [31:0] v, input logic last);
		vertex_item_t item;
		item.vidx = v;
		item.last = last;
		index_feed.push_back(item);
		items_queued++;
	endtask

	task automatic mark_last();
		vertex_item_t item;
		item = index_feed.pop_back();
		item.last = 1'b1;
		index_feed.push_back(item);
	endtask

	function automatic logic [31:0] good_index();
		int unsigned limit;
		limit = (point_limit > MAX_POINTS) ? MAX_POINTS : point_limit;
		if (limit == 0) begin
			return $urandom_range(0, 15);
		end
		return $urandom_range(0, limit - 1);
	endfunction

	function automatic logic [31:0] bad_index();
		logic [31:0] v;
		case ($urandom_range(0, 3))
			0: v = point_limit + $urandom_range(0, 3);
			1: v = {1'b1, 31'($urandom)};
			2: v = $urandom;
			default: v = 32'hFFFF_FFFE;
		endcase
		return (v == pft_pkg::END_OF_FACE) ? 32'h8000_0000 : v;
	endfunction

	// One index list made of fan faces, with a few broken faces and bad indices.
	task automatic queue_list();
		int          faces;
		int          corners;
		int unsigned start;
		start = items_queued;
		faces = $urandom_range(1, 5);
		for (int f = 0; f < faces; f++) begin
			corners = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
			for (int c = 0; c < corners; c++) begin
				push_index(($urandom_range(0, 39) == 0) ? bad_index() : good_index(), 1'b0);
			end
			if (f < faces - 1 || $urandom_range(0, 3) != 0 || items_queued == start) begin
				push_index(pft_pkg::END_OF_FACE, 1'b0);
			end
		end
		mark_last();
	endtask

	task automatic queue_noise();
		int n;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 2))
				0: push_index(pft_pkg::END_OF_FACE, $urandom_range(0, 3) == 0);
				1: push_index($urandom, $urandom_range(0, 3) == 0);
				default: push_index(good_index(), $urandom_range(0, 3) == 0);
			endcase
		end
		mark_last();
	endtask

	task automatic wait_drained();
		while (index_feed.size() != 0 || s_tvalid || fan_expected.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input logic idx, input logic [16:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		case (idx)
			pft_pkg::REG_POINT_COUNT: point_limit = val;
			default: ccw = val[0];
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(input logic [16:0] count, input logic winding);
		wait_drained();
		repeat (6) @(posedge clk);
		write_reg(pft_pkg::REG_POINT_COUNT, count);
		write_reg(pft_pkg::REG_COUNTER_CLOCKWISE, {16'd0, winding});
	endtask

	initial begin
		logic [16:0] counts[6];
		logic        windings[6];
		counts = '{17'd20, 17'd0, 17'd65536, 17'd1, 17'd4, 17'd65536};
		windings = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
		counts[3] = 17'($urandom_range(1, 65536));
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		configure(17'd65536, 1'b1);
		// Extreme indices, then a full face ending on a vertex marked last.
		push_index(32'd0, 1'b0);
		push_index(32'd65535, 1'b0);
		push_index(32'd1, 1'b0);
		push_index(pft_pkg::END_OF_FACE, 1'b0);
		push_index(32'd7, 1'b0);
		push_index(32'd8, 1'b0);
		push_index(32'd9, 1'b0);
		push_index(32'd10, 1'b1);
		// End of face first in the list.
		push_index(pft_pkg::END_OF_FACE, 1'b1);
		// Short faces closed by the last item.
		push_index(32'd5, 1'b0);
		push_index(32'd6, 1'b1);
		push_index(32'd5, 1'b1);
		// Short face, then items dropped up to the end of the list.
		push_index(32'd3, 1'b0);
		push_index(pft_pkg::END_OF_FACE, 1'b0);
		push_index(32'd4, 1'b0);
		push_index(32'h7FFF_FFFF, 1'b0);
		push_index(pft_pkg::END_OF_FACE, 1'b1);
		// Indices out of range on both sides.
		push_index(32'd65536, 1'b1);
		push_index(32'hFFFF_FFFE, 1'b0);
		push_index(32'h8000_0000, 1'b1);
		// Two face ends in a row after a good face.
		push_index(32'd1, 1'b0);
		push_index(32'd2, 1'b0);
		push_index(32'd3, 1'b0);
		push_index(pft_pkg::END_OF_FACE, 1'b0);
		push_index(pft_pkg::END_OF_FACE, 1'b1);

		configure(17'd65536, 1'b0);
		push_index(32'd10, 1'b0);
		push_index(32'd20, 1'b0);
		push_index(32'd30, 1'b0);
		push_index(32'd40, 1'b0);
		push_index(pft_pkg::END_OF_FACE, 1'b1);

		for (int p = 0; p < 6; p++) begin
			configure(counts[p], windings[p]);
			items_queued = 0;
			while (items_queued < ITEMS_PER_PHASE) begin
				if (items_queued >= ITEMS_PER_PHASE / 2 && items_queued < ITEMS_PER_PHASE / 2 + 8) begin
					wait_drained();
				end
				if ($urandom_range(0, 7) == 0) begin
					queue_noise();
				end else begin
					queue_list();
				end
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+design
design/pft_pkg.sv
design/pft_front.sv
design/pft_queue.sv
design/pft_back.sv
design/polygon_fan_triangulator_top.sv
design/pft_checker.sv
test/polygon_fan_triangulator_top_tb.sv
